@@ sv/cppd_pkg.sv @@
package cppd_pkg;

    // result codes carried on the master tuser
    typedef enum logic [2:0] {
        ST_STARTED  = 3'd0,
        ST_QUEUED   = 3'd1,
        ST_GRANTED  = 3'd2,
        ST_FREED    = 3'd3,
        ST_DROPPED  = 3'd4,
        ST_IGNORED  = 3'd5
    } status_t;

    // command codes carried on the slave tuser
    localparam logic CMD_REQUEST = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    // fixed field widths
    localparam int unsigned ID_W    = 8;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned CORES_W = 7;
    localparam int unsigned TDATA_W = 80;

    // one waiting process
    typedef struct packed {
        logic [TIME_W-1:0] len;
        logic [ID_W-1:0]   id;
    } entry_t;

    // queue flags seen by the dispatch logic
    typedef struct packed {
        logic empty;
        logic full;
    } fifo_status_t;

endpackage

@@ sv/cppd_ram.sv @@
module cppd_ram #(
    parameter int unsigned WIDTH = 40,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // single write port, registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/cppd_fifo.sv @@
module cppd_fifo #(
    parameter int unsigned DEPTH = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  cppd_pkg::entry_t      push_data,
    input  logic                  pop,
    output cppd_pkg::entry_t      head_data,
    output cppd_pkg::fifo_status_t status
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam int unsigned ENT_W = $bits(cppd_pkg::entry_t);

    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             byp_valid_reg;
    cppd_pkg::entry_t byp_data_reg;
    logic [ENT_W-1:0] ram_rd_data;

    // pointer advance with wrap at the queue depth
    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (pop) begin
            head_next = (head_reg == PTR_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
        end
        if (push) begin
            tail_next = (tail_reg == PTR_W'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            byp_valid_reg <= 1'b0;
        end else begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            byp_valid_reg <= push && (tail_reg == head_next);
        end
    end

    // write landing on the slot being read: forward it past the ram
    always_ff @(posedge aclk) begin
        byp_data_reg <= push_data;
    end

    // ram always reads the next head so the head entry is ready each cycle
    cppd_ram #(
        .WIDTH(ENT_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .aclk   (aclk),
        .wr_en  (push),
        .wr_addr(tail_reg),
        .wr_data(push_data),
        .rd_addr(head_next),
        .rd_data(ram_rd_data)
    );

    assign head_data    = byp_valid_reg ? byp_data_reg : cppd_pkg::entry_t'(ram_rd_data);
    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == CNT_W'(DEPTH));

    // checks
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (count_reg != '0))
        else $error("pop on empty queue");
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |-> (count_reg != CNT_W'(DEPTH)))
        else $error("push on full queue");
    a_empty_ptrs: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (head_reg == tail_reg))
        else $error("empty queue with unequal pointers");

endmodule

@@ sv/core_pool_two_priority_dispatcher.sv @@
// path: an accepted transaction is captured in the input register and moves on to the
//   result register once that register is empty or being read, so a stalled master holds it
// throughput: one request or release per cycle while the master does not stall; the
//   free-core count and both queue heads update together as a transaction advances; queue
//   heads come from registered-read ram with a write-forwarding register
// reset: synchronous active low; core_count and free cores go to 1, both queues empty
module core_pool_two_priority_dispatcher #(
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // slave stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // pid[7:0], run_length[39:8],
                                   // interactive[40], now[72:41], zero pad
    input  logic        s_tuser,   // command
    // master stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // granted_id[7:0], finish_time[39:8],
                                   // granted_length[71:40], from_interactive[72], zero pad
    output logic [2:0]  m_tuser,   // status
    // core count register write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data
);

    localparam int unsigned ID_W    = cppd_pkg::ID_W;
    localparam int unsigned TIME_W  = cppd_pkg::TIME_W;
    localparam int unsigned CORES_W = cppd_pkg::CORES_W;

    // input stage
    logic              in_valid_reg;
    logic              in_cmd_reg;
    logic [ID_W-1:0]   in_pid_reg;
    logic [TIME_W-1:0] in_len_reg;
    logic              in_inter_reg;
    logic [TIME_W-1:0] in_now_reg;

    // result stage
    logic              out_valid_reg;
    cppd_pkg::status_t out_status_reg, out_status_next;
    logic [ID_W-1:0]   out_gid_reg, out_gid_next;
    logic [TIME_W-1:0] out_finish_reg;
    logic [TIME_W-1:0] out_len_reg, out_len_next;
    logic              out_fromi_reg, out_fromi_next;

    // pool state
    logic [CORES_W-1:0] core_count_reg;
    logic [CORES_W-1:0] free_cores_reg, free_cores_next;

    // queues
    logic                  hi_push, lo_push, hi_pop, lo_pop;
    cppd_pkg::entry_t      new_entry, hi_head, lo_head;
    cppd_pkg::fifo_status_t hi_status, lo_status;

    logic advance;
    logic s_accept;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_cmd_reg   <= s_tuser;
            in_pid_reg   <= s_tdata[7:0];
            in_len_reg   <= s_tdata[39:8];
            in_inter_reg <= s_tdata[40];
            in_now_reg   <= s_tdata[72:41];
        end
    end

    assign new_entry.id  = in_pid_reg;
    assign new_entry.len = in_len_reg;

    // dispatch decision
    always_comb begin
        free_cores_next = free_cores_reg;
        hi_push         = 1'b0;
        lo_push         = 1'b0;
        hi_pop          = 1'b0;
        lo_pop          = 1'b0;
        out_status_next = cppd_pkg::ST_IGNORED;
        out_gid_next    = '0;
        out_len_next    = '0;
        out_fromi_next  = 1'b0;
        if (in_cmd_reg == cppd_pkg::CMD_REQUEST) begin
            if (free_cores_reg != '0) begin
                free_cores_next = free_cores_reg - 1'b1;
                out_status_next = cppd_pkg::ST_STARTED;
                out_gid_next    = in_pid_reg;
                out_len_next    = in_len_reg;
            end else begin
                out_fromi_next = in_inter_reg;
                if (in_inter_reg ? hi_status.full : lo_status.full) begin
                    out_status_next = cppd_pkg::ST_DROPPED;
                end else begin
                    out_status_next = cppd_pkg::ST_QUEUED;
                    hi_push         = advance && in_inter_reg;
                    lo_push         = advance && !in_inter_reg;
                end
            end
        end else begin
            if (!hi_status.empty) begin
                hi_pop          = advance;
                out_status_next = cppd_pkg::ST_GRANTED;
                out_fromi_next  = 1'b1;
                out_gid_next    = hi_head.id;
                out_len_next    = hi_head.len;
            end else if (!lo_status.empty) begin
                lo_pop          = advance;
                out_status_next = cppd_pkg::ST_GRANTED;
                out_gid_next    = lo_head.id;
                out_len_next    = lo_head.len;
            end else if (free_cores_reg < core_count_reg) begin
                free_cores_next = free_cores_reg + 1'b1;
                out_status_next = cppd_pkg::ST_FREED;
            end else begin
                out_status_next = cppd_pkg::ST_IGNORED;
            end
        end
    end

    // pool counters; a register write reloads the free count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            core_count_reg <= CORES_W'(1);
            free_cores_reg <= CORES_W'(1);
        end else if (cfg_valid) begin
            core_count_reg <= cfg_data;
            free_cores_reg <= cfg_data;
        end else if (advance) begin
            free_cores_reg <= free_cores_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_status_reg <= out_status_next;
            out_gid_reg    <= out_gid_next;
            out_len_reg    <= out_len_next;
            out_fromi_reg  <= out_fromi_next;
            out_finish_reg <= (out_len_next == '0 && out_gid_next == '0 &&
                               out_status_next != cppd_pkg::ST_STARTED &&
                               out_status_next != cppd_pkg::ST_GRANTED)
                              ? '0 : in_now_reg + out_len_next;
        end
    end

    // waiting queues
    cppd_fifo #(
        .DEPTH(QUEUE_DEPTH)
    ) u_hi_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (hi_push),
        .push_data(new_entry),
        .pop      (hi_pop),
        .head_data(hi_head),
        .status   (hi_status)
    );

    cppd_fifo #(
        .DEPTH(QUEUE_DEPTH)
    ) u_lo_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (lo_push),
        .push_data(new_entry),
        .pop      (lo_pop),
        .head_data(lo_head),
        .status   (lo_status)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {7'd0, out_fromi_reg, out_len_reg, out_finish_reg, out_gid_reg};

    // checks
    a_free_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        free_cores_reg <= core_count_reg)
        else $error("free cores above core count");
    a_hi_push_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        (hi_push && !hi_pop) |=> !hi_status.empty)
        else $error("interactive queue empty after push");
    a_batch_waits_hi: assert property (@(posedge aclk) disable iff (!aresetn)
        lo_pop |-> hi_status.empty)
        else $error("batch waiter served ahead of interactive waiter");
    a_queue_only_no_core: assert property (@(posedge aclk) disable iff (!aresetn)
        (hi_push || lo_push) |-> (free_cores_reg == '0))
        else $error("request queued while a core is free");

endmodule

@@ tb/sv/core_pool_two_priority_dispatcher_tb.sv @@
`timescale 1ns / 1ps

module core_pool_two_priority_dispatcher_tb;

    localparam int unsigned QUEUE_DEPTH = 16;
    localparam int unsigned PHASE_ITEMS = 50;

    // one request or release as carried on the slave stream
    typedef struct packed {
        logic        cmd;
        logic [7:0]  pid;
        logic [31:0] len;
        logic        inter;
        logic [31:0] stamp;
    } dispatch_req_t;

    // one result as carried on the master stream
    typedef struct packed {
        cppd_pkg::status_t status;
        logic [7:0]        gid;
        logic [31:0]       finish;
        logic [31:0]       glen;
        logic              fromi;
    } outcome_t;

    // one line of the directed script: either a core count write or an item
    typedef struct {
        logic          do_cfg;
        logic [6:0]    cfg_val;
        int            reps;
        dispatch_req_t item;
        logic          typed;
        outcome_t      want;
    } script_row_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata   = '0;
    logic        s_tuser   = cppd_pkg::CMD_REQUEST;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [79:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [6:0]  cfg_data  = '0;

    // predictor state
    logic [6:0]       cores_total = 7'd1;
    logic [6:0]       cores_idle  = 7'd1;
    cppd_pkg::entry_t interactive_wait[$];
    cppd_pkg::entry_t batch_wait[$];
    outcome_t         expected_outcomes[$];
    outcome_t         oldest;

    int   error_count = 0;
    logic gaps_on     = 1'b1;
    logic stalls_on   = 1'b1;

    script_row_t script [0:14];

    core_pool_two_priority_dispatcher #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #10 aclk = ~aclk;

    // gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 30);
    endfunction

    // expected outcome of one accepted transaction, advancing the pool state
    function automatic outcome_t predict_dispatch(input dispatch_req_t it);
        outcome_t         o;
        cppd_pkg::entry_t e;
        o = '{cppd_pkg::ST_IGNORED, 8'h00, 32'h0, 32'h0, 1'b0};
        if (it.cmd == cppd_pkg::CMD_REQUEST) begin
            if (cores_idle != 0) begin
                cores_idle = cores_idle - 7'd1;
                o.status = cppd_pkg::ST_STARTED;
                o.gid    = it.pid;
                o.glen   = it.len;
                o.finish = it.stamp + it.len;
            end else begin
                o.fromi = it.inter;
                e.id    = it.pid;
                e.len   = it.len;
                o.status = cppd_pkg::ST_DROPPED;
                if (it.inter && interactive_wait.size() < QUEUE_DEPTH) begin
                    interactive_wait.push_back(e);
                    o.status = cppd_pkg::ST_QUEUED;
                end else if (!it.inter && batch_wait.size() < QUEUE_DEPTH) begin
                    batch_wait.push_back(e);
                    o.status = cppd_pkg::ST_QUEUED;
                end
            end
        end else if (interactive_wait.size() != 0) begin
            e = interactive_wait.pop_front();
            o.status = cppd_pkg::ST_GRANTED;
            o.fromi  = 1'b1;
            o.gid    = e.id;
            o.glen   = e.len;
            o.finish = it.stamp + e.len;
        end else if (batch_wait.size() != 0) begin
            e = batch_wait.pop_front();
            o.status = cppd_pkg::ST_GRANTED;
            o.gid    = e.id;
            o.glen   = e.len;
            o.finish = it.stamp + e.len;
        end else if (cores_idle < cores_total) begin
            cores_idle = cores_idle + 7'd1;
            o.status = cppd_pkg::ST_FREED;
        end
        return o;
    endfunction

    // drive one transaction and record its expected outcome once accepted
    task automatic send_item(input dispatch_req_t it, input logic typed, input outcome_t want);
        int       gap;
        outcome_t predicted;
        gap = gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, it.stamp, it.inter, it.len, it.pid};
        s_tuser  <= it.cmd;
        do @(posedge aclk); while (!s_tready);
        predicted = predict_dispatch(it);
        expected_outcomes.push_back(typed ? want : predicted);
    endtask

    // stop sending and wait for every outstanding result, then the pipeline
    task automatic settle();
        s_tvalid <= 1'b0;
        while (expected_outcomes.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // core count write; also reloads the idle core count
    task automatic write_core_count(input logic [6:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid   <= 1'b0;
        cores_total = value;
        cores_idle  = value;
    endtask

    function automatic dispatch_req_t random_item(input int request_pct);
        dispatch_req_t it;
        int            r;
        it.cmd   = ($urandom_range(0, 99) < request_pct) ? cppd_pkg::CMD_REQUEST
                                                         : cppd_pkg::CMD_RELEASE;
        it.pid   = 8'($urandom);
        it.inter = 1'($urandom_range(0, 1));
        it.stamp = $urandom;
        r = $urandom_range(0, 9);
        it.len   = (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF : $urandom;
        return it;
    endfunction

    task automatic compare_field(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            error_count++;
        end
    endtask

    // result checker against the oldest expected outcome
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_outcomes.size() == 0) begin
                $error("result transaction with no expected outcome waiting");
                error_count++;
            end else begin
                oldest = expected_outcomes.pop_front();
                compare_field("status", 32'(oldest.status), 32'(m_tuser));
                compare_field("granted_id", 32'(oldest.gid), 32'(m_tdata[7:0]));
                compare_field("finish_time", oldest.finish, m_tdata[39:8]);
                compare_field("granted_length", oldest.glen, m_tdata[71:40]);
                compare_field("from_interactive", 32'(oldest.fromi), 32'(m_tdata[72]));
            end
        end
    end

    // receiver back-pressure
    initial begin
        int span;
        forever begin
            span = $urandom_range(1, 40);
            m_tready <= 1'b1;
            repeat (span) @(posedge aclk);
            if (stalls_on) begin
                span = (pick_gap() > 5) ? $urandom_range(8, 40) : $urandom_range(1, 3);
                m_tready <= 1'b0;
                repeat (span) @(posedge aclk);
            end
        end
    end

    // run limit
    initial begin
        #5_000_000;
        $display("core_pool_two_priority_dispatcher_tb: done, errors");
        $finish;
    end

    // stimulus
    initial begin
        logic [6:0]    phase_cores [0:7];
        dispatch_req_t req;
        int            request_pct;

        // directed script: reset state, wrap-around, priority order, full queue, extremes
        script = '{
            '{1'b0, 7'd0, 1,
              '{cppd_pkg::CMD_RELEASE, 8'h00, 32'h0, 1'b0, 32'h0}, 1'b1,
              '{cppd_pkg::ST_IGNORED, 8'h00, 32'h0, 32'h0, 1'b0}},
            '{1'b0, 7'd0, 1,
              '{cppd_pkg::CMD_REQUEST, 8'hFF, 32'hFFFF_FFFF, 1'b0, 32'h1}, 1'b1,
              '{cppd_pkg::ST_STARTED, 8'hFF, 32'h0, 32'hFFFF_FFFF, 1'b0}},
            '{1'b0, 7'd0, 1,
              '{cppd_pkg::CMD_REQUEST, 8'h00, 32'h0, 1'b1, 32'hFFFF_FFFF}, 1'b1,
              '{cppd_pkg::ST_QUEUED, 8'h00, 32'h0, 32'h0, 1'b1}},
            '{1'b0, 7'd0, 1,
              '{cppd_pkg::CMD_REQUEST, 8'h5A, 32'h1234_5678, 1'b0, 32'h0}, 1'b1,
              '{cppd_pkg::ST_QUEUED, 8'h00, 32'h0, 32'h0, 1'b0}},
            '{1'b0, 7'd0, 1,
              '{cppd_pkg::CMD_RELEASE, 8'h00, 32'h0, 1'b0, 32'h10}, 1'b1,
              '{cppd_pkg::ST_GRANTED, 8'h00, 32'h10, 32'h0, 1'b1}},
            '{1'b0, 7'd0, 1,
              '{cppd_pkg::CMD_RELEASE, 8'h00, 32'h0, 1'b1, 32'hFFFF_FFF0}, 1'b1,
              '{cppd_pkg::ST_GRANTED, 8'h5A, 32'h1234_5668, 32'h1234_5678, 1'b0}},
            '{1'b0, 7'd0, 1,
              '{cppd_pkg::CMD_RELEASE, 8'h00, 32'h0, 1'b0, 32'h0}, 1'b1,
              '{cppd_pkg::ST_FREED, 8'h00, 32'h0, 32'h0, 1'b0}},
            '{1'b0, 7'd0, 1,
              '{cppd_pkg::CMD_RELEASE, 8'h00, 32'h0, 1'b0, 32'h0}, 1'b1,
              '{cppd_pkg::ST_IGNORED, 8'h00, 32'h0, 32'h0, 1'b0}},
            // zero cores: everything waits until the interactive queue overflows
            '{1'b1, 7'd0, 0,
              '{cppd_pkg::CMD_REQUEST, 8'h00, 32'h0, 1'b0, 32'h0}, 1'b0,
              '{cppd_pkg::ST_STARTED, 8'h00, 32'h0, 32'h0, 1'b0}},
            '{1'b0, 7'd0, 16,
              '{cppd_pkg::CMD_REQUEST, 8'h10, 32'hA5A5_5A5A, 1'b1, 32'h1000}, 1'b0,
              '{cppd_pkg::ST_STARTED, 8'h00, 32'h0, 32'h0, 1'b0}},
            '{1'b0, 7'd0, 1,
              '{cppd_pkg::CMD_REQUEST, 8'hAB, 32'h1, 1'b1, 32'h0}, 1'b1,
              '{cppd_pkg::ST_DROPPED, 8'h00, 32'h0, 32'h0, 1'b1}},
            '{1'b0, 7'd0, 1,
              '{cppd_pkg::CMD_REQUEST, 8'hC3, 32'h7, 1'b0, 32'h0}, 1'b1,
              '{cppd_pkg::ST_QUEUED, 8'h00, 32'h0, 32'h0, 1'b0}},
            '{1'b0, 7'd0, 1,
              '{cppd_pkg::CMD_RELEASE, 8'h00, 32'h0, 1'b0, 32'h2000}, 1'b0,
              '{cppd_pkg::ST_STARTED, 8'h00, 32'h0, 32'h0, 1'b0}},
            // largest pool
            '{1'b1, 7'd127, 0,
              '{cppd_pkg::CMD_REQUEST, 8'h00, 32'h0, 1'b0, 32'h0}, 1'b0,
              '{cppd_pkg::ST_STARTED, 8'h00, 32'h0, 32'h0, 1'b0}},
            '{1'b0, 7'd0, 1,
              '{cppd_pkg::CMD_REQUEST, 8'h7E, 32'h8000_0000, 1'b1, 32'h8000_0000}, 1'b1,
              '{cppd_pkg::ST_STARTED, 8'h7E, 32'h0, 32'h8000_0000, 1'b0}}
        };
        phase_cores = '{7'd1, 7'd0, 7'd2, 7'd127, 7'd3, 7'd64, 7'd0, 7'd5};
        phase_cores[7] = 7'($urandom_range(1, 64));

        // reset
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part
        for (int i = 0; i <= 14; i++) begin
            if (script[i].do_cfg) begin
                settle();
                write_core_count(script[i].cfg_val);
            end else begin
                for (int k = 0; k < script[i].reps; k++) begin
                    req = script[i].item;
                    req.pid = req.pid + 8'(k);
                    send_item(req, script[i].typed, script[i].want);
                end
            end
        end

        // random phases, one pool size each, queues carried across
        for (int p = 0; p < 8; p++) begin
            settle();
            write_core_count(phase_cores[p]);
            gaps_on     = ($urandom_range(0, 3) != 0);
            stalls_on   = ($urandom_range(0, 3) != 0);
            request_pct = (p % 3 == 0) ? 35 : (p % 3 == 1) ? 75 : 55;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_item(random_item(request_pct), 1'b0, oldest);
            end
        end

        settle();
        repeat (6) @(posedge aclk);
        if (error_count == 0) begin
            $display("core_pool_two_priority_dispatcher_tb: done, clean");
        end else begin
            $display("core_pool_two_priority_dispatcher_tb: done, errors");
        end
        $finish;
    end

endmodule
